@@ rtl/rfalu_pkg.sv @@
// Shared types and constants for the register file ALU block.
package rfalu_pkg;

    // Operation codes carried in the cmd field.
    localparam logic [2:0] CMD_CMOV = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_NAND = 3'd4;
    localparam logic [2:0] CMD_LDI  = 3'd5;
    localparam logic [2:0] CMD_OUT  = 3'd6;
    localparam logic [2:0] CMD_IN   = 3'd7;

    localparam int         WORD_W    = 32;
    localparam int         IDX_W     = 3;
    localparam int         IDX_EXT_W = 5;
    localparam int         DIV_STEPS = 32;
    localparam int         CNT_W     = 5;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CHAR_MASK = 32'h0000_00FF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  reg_a;
        logic [2:0]  reg_b;
        logic [2:0]  reg_c;
        logic [31:0] immediate;
        logic [8:0]  in_char;
    } t_in;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_value;
        logic       div_fault;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul_wr;
        logic div_start;
        logic div_step;
        logic div_wr;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       vc_zero;
    } t_dp_sts;

endpackage

@@ rtl/rfalu_ctrl.sv @@
// Controller state machine that sequences one operation at a time.
module rfalu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  rfalu_pkg::t_dp_sts  i_sts,
    output rfalu_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [rfalu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.cmd == rfalu_pkg::CMD_MUL) begin
                    n_state = S_MUL;
                end else if (i_sts.cmd == rfalu_pkg::CMD_DIV && !i_sts.vc_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + rfalu_pkg::CNT_W'(1);
                if (r_cnt == rfalu_pkg::CNT_W'(rfalu_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                o_cmd.div_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && i_out_stall) || o_cmd.load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/rfalu_dp.sv @@
// Datapath: register file memory, operand registers, multiplier and serial divider.
module rfalu_dp #(
    parameter int NUM_REGS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfalu_pkg::t_in      i_in,
    input  rfalu_pkg::t_dp_cmd  i_cmd,
    output rfalu_pkg::t_dp_sts  o_sts,
    output rfalu_pkg::t_out     o_out
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int XW = rfalu_pkg::IDX_EXT_W;

    logic [31:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;

    // Captured item fields.
    logic [2:0]  r_op;
    logic [2:0]  r_a;
    logic [2:0]  r_c;
    logic [31:0] r_imm;
    logic [8:0]  r_char;

    // Registered memory reads and their validity.
    logic [31:0] r_rd_b, r_rd_c;
    logic        r_ok_b, r_ok_c;
    logic [31:0] vb, vc;

    logic [31:0] r_prod;
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [32:0] shifted, diff;

    rfalu_pkg::t_out r_res, r_out;

    logic [XW-1:0] ext_b, ext_c, ext_w;
    logic [AW-1:0] idx_b, idx_c, idx_w;
    logic          in_b, in_c, in_w;
    logic          wr_req, wr_en;
    logic [2:0]    wr_sel;
    logic [31:0]   wr_data;

    assign ext_b = {{(XW - rfalu_pkg::IDX_W){1'b0}}, i_in.reg_b};
    assign ext_c = {{(XW - rfalu_pkg::IDX_W){1'b0}}, i_in.reg_c};
    assign idx_b = ext_b[AW-1:0];
    assign idx_c = ext_c[AW-1:0];
    assign in_b  = (ext_b < XW'(NUM_REGS));
    assign in_c  = (ext_c < XW'(NUM_REGS));

    assign vb = r_ok_b ? r_rd_b : '0;
    assign vc = r_ok_c ? r_rd_c : '0;

    // Write port selection; the input command targets register C.
    always_comb begin
        wr_req  = 1'b0;
        wr_sel  = r_a;
        wr_data = '0;
        if (i_cmd.exec) begin
            unique case (r_op)
                rfalu_pkg::CMD_CMOV: begin
                    wr_req  = (vc != '0);
                    wr_data = vb;
                end
                rfalu_pkg::CMD_ADD: begin
                    wr_req  = 1'b1;
                    wr_data = vb + vc;
                end
                rfalu_pkg::CMD_NAND: begin
                    wr_req  = 1'b1;
                    wr_data = ~(vb & vc);
                end
                rfalu_pkg::CMD_LDI: begin
                    wr_req  = 1'b1;
                    wr_data = r_imm;
                end
                rfalu_pkg::CMD_IN: begin
                    wr_req  = 1'b1;
                    wr_sel  = r_c;
                    wr_data = r_char[8] ? rfalu_pkg::ALL_ONES
                                        : ({24'd0, r_char[7:0]} & rfalu_pkg::CHAR_MASK);
                end
                default: begin
                    wr_req = 1'b0;
                end
            endcase
        end else if (i_cmd.mul_wr) begin
            wr_req  = 1'b1;
            wr_data = r_prod;
        end else if (i_cmd.div_wr) begin
            wr_req  = 1'b1;
            wr_data = r_quo;
        end
    end

    assign ext_w = {{(XW - rfalu_pkg::IDX_W){1'b0}}, wr_sel};
    assign idx_w = ext_w[AW-1:0];
    assign in_w  = (ext_w < XW'(NUM_REGS));
    assign wr_en = wr_req && in_w;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[idx_w] <= wr_data;
        end
        if (i_cmd.capture) begin
            r_rd_b <= mem[idx_b];
            r_rd_c <= mem[idx_c];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[idx_w] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in.cmd;
            r_a    <= i_in.reg_a;
            r_c    <= i_in.reg_c;
            r_imm  <= i_in.immediate;
            r_char <= i_in.in_char;
            r_ok_b <= in_b && r_vld[idx_b];
            r_ok_c <= in_c && r_vld[idx_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_prod               <= vb * vc;
            r_res.char_valid     <= (r_op == rfalu_pkg::CMD_OUT);
            r_res.char_value     <= (r_op == rfalu_pkg::CMD_OUT) ? vc[7:0] : 8'd0;
            r_res.div_fault      <= (r_op == rfalu_pkg::CMD_DIV) && (vc == '0);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= vb;
            r_dvs <= vc;
        end else if (i_cmd.div_step) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_sts.cmd     = r_op;
    assign o_sts.vc_zero = (vc == '0);
    assign o_out         = r_out;

endmodule

@@ rtl/register_file_alu_ops.sv @@
// Top level of the register file ALU: controller plus datapath.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in  (cmd, indexes, data)
//  out     | output    | o_out_valid / i_out_stall| o_out (char, fault flags)
//
// One transfer is processed at a time. After the accepting edge, most operations and a
// divide by zero run execute and then load the output register; multiply adds a product
// write-back before the load, and divide adds 32 restoring steps and a quotient write-back;
// the next transfer can be accepted on the cycle following the load.
// Reset clears the controller and the per-register valid bits, so every register reads
// as zero until first written. An untaken result under output stall keeps the input stalled.
module register_file_alu_ops #(
    parameter int NUM_REGS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rfalu_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rfalu_pkg::t_out o_out
);

    // Command and status between the state machine and the datapath.
    rfalu_pkg::t_dp_cmd dp_cmd;
    rfalu_pkg::t_dp_sts dp_sts;

    // The controller owns the handshakes and the divide step counter.
    rfalu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the registers, the arithmetic and the result register.
    rfalu_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_out   (o_out)
    );

endmodule

@@ tb/sv/tb_register_file_alu_ops.sv @@
// Self-checking testbench for the register file ALU: a directed table, then random phases.
module tb_register_file_alu_ops;

    // Sizes of the run. The random items are split evenly over the random phases.
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 1300;
    localparam int N_PHASES     = 4;
    // Length of the long output hold-off, in cycles. It is far longer than the
    // block's slowest operation, so the block fills up and stalls its input.
    localparam int LONG_HOLD    = 300;
    // The margin is longer than a divide takes from acceptance to the output
    // register, so it is enough to catch a stray result after the last expected one.
    localparam int DRAIN_CYCLES = 40;
    // Time limit for the run, several times what the slowest correct run needs.
    localparam int RUN_LIMIT    = 8_000_000;

    // A directed row either carries a result typed in by hand or takes the
    // predicted one.
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam rfalu_pkg::t_out RES_QUIET  = '0;
    localparam rfalu_pkg::t_out RES_FAULT  =
        '{char_valid: 1'b0, char_value: 8'h00, div_fault: 1'b1};
    localparam rfalu_pkg::t_out RES_CHAR00 =
        '{char_valid: 1'b1, char_value: 8'h00, div_fault: 1'b0};
    localparam rfalu_pkg::t_out RES_CHARFF =
        '{char_valid: 1'b1, char_value: 8'hFF, div_fault: 1'b0};

    typedef struct packed {
        rfalu_pkg::t_in  op;
        logic            typed;
        rfalu_pkg::t_out res;
    } t_row;

    // Every input of the block holds a known value from time zero.
    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    rfalu_pkg::t_in  i_in        = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    rfalu_pkg::t_out o_out;

    // Our own copy of the register file, advanced once per accepted transfer.
    logic [rfalu_pkg::WORD_W-1:0] reg_copy [8];
    // Results still owed by the block, oldest first.
    rfalu_pkg::t_out pending_results [$];
    int   mismatches = 0;

    // Idling odds, in percent, for the phase that is running.
    int idle_pct  = 0;
    int stall_pct = 0;
    // The stimulus asks for a long hold-off by bumping the request count; the
    // output side serves each request once and counts the cycles itself.
    int holds_requested = 0;
    int holds_served    = 0;
    int hold_left       = 0;

    register_file_alu_ops u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Runs one register operation on the local copy and returns its result.
    // Multiply keeps the low 32 bits because the expression is sized to the
    // destination. An input byte with bit 8 set marks end of input.
    function automatic rfalu_pkg::t_out exec_reg_op(input rfalu_pkg::t_in op);
        logic [rfalu_pkg::WORD_W-1:0] vb;
        logic [rfalu_pkg::WORD_W-1:0] vc;
        rfalu_pkg::t_out r;
        vb = reg_copy[op.reg_b];
        vc = reg_copy[op.reg_c];
        r  = RES_QUIET;
        case (op.cmd)
            rfalu_pkg::CMD_CMOV: if (vc != '0) reg_copy[op.reg_a] = vb;
            rfalu_pkg::CMD_ADD:  reg_copy[op.reg_a] = vb + vc;
            rfalu_pkg::CMD_MUL:  reg_copy[op.reg_a] = vb * vc;
            rfalu_pkg::CMD_DIV: begin
                if (vc == '0) r.div_fault = 1'b1;
                else reg_copy[op.reg_a] = vb / vc;
            end
            rfalu_pkg::CMD_NAND: reg_copy[op.reg_a] = ~(vb & vc);
            rfalu_pkg::CMD_LDI:  reg_copy[op.reg_a] = op.immediate;
            rfalu_pkg::CMD_OUT: begin
                r.char_valid = 1'b1;
                r.char_value = vc[7:0];
            end
            rfalu_pkg::CMD_IN: begin
                reg_copy[op.reg_c] = op.in_char[8] ? rfalu_pkg::ALL_ONES
                                                   : {23'd0, op.in_char};
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic rfalu_pkg::t_in mk(input logic [2:0] cmd, input logic [2:0] a,
                                          input logic [2:0] b, input logic [2:0] c,
                                          input logic [31:0] imm, input logic [8:0] ch);
        rfalu_pkg::t_in op;
        op = '{cmd: cmd, reg_a: a, reg_b: b, reg_c: c, immediate: imm, in_char: ch};
        return op;
    endfunction

    // Random operation. Load immediate is favored so that the registers keep
    // picking up fresh values, and the immediates mix full words, small
    // numbers, shifted words and corner values, so that divides see both large
    // and small divisors. About one input in seven is end of input.
    function automatic rfalu_pkg::t_in rand_op();
        rfalu_pkg::t_in op;
        op.cmd   = ($urandom_range(0, 99) < 18) ? rfalu_pkg::CMD_LDI
                                                : 3'($urandom_range(0, 7));
        op.reg_a = 3'($urandom_range(0, 7));
        op.reg_b = 3'($urandom_range(0, 7));
        op.reg_c = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: op.immediate = $urandom();
            1: op.immediate = $urandom_range(0, 15);
            2: op.immediate = $urandom() >> $urandom_range(0, 31);
            default: begin
                case ($urandom_range(0, 3))
                    0: op.immediate = '0;
                    1: op.immediate = rfalu_pkg::ALL_ONES;
                    2: op.immediate = 32'h8000_0000;
                    default: op.immediate = 32'd1;
                endcase
            end
        endcase
        op.in_char = ($urandom_range(0, 99) < 15) ? 9'($urandom_range(256, 511))
                                                  : 9'($urandom_range(0, 255));
        return op;
    endfunction

    // Offers one item, starting and ending at a falling edge. Idle cycles come
    // first, with junk on the payload while valid is low. Once valid is high
    // the payload holds until the transfer, which is seen at a rising edge with
    // the input not stalled; the expectation is queued right there.
    task automatic send_op(input rfalu_pkg::t_in op, input logic typed,
                           input rfalu_pkg::t_out typed_res);
        rfalu_pkg::t_out predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            i_in       = rand_op();
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in       = op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = exec_reg_op(op);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // The sender goes quiet until every expected result has been taken.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random stalls at the rate of the phase, or a long hold-off
    // when one has been requested. Changes happen at the falling edge only.
    always @(negedge i_clk) begin
        if (holds_served < holds_requested) begin
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Checker: every transfer on the output is compared field by field with
    // the oldest expectation. A result with none pending is an error as well.
    always @(posedge i_clk) begin
        rfalu_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual valid %0d value 0x%02h fault %0d",
                         $time, o_out.char_valid, o_out.char_value, o_out.div_fault);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.char_valid !== want.char_valid) begin
                    $display("%0t: char_valid mismatch: expected %0d actual %0d",
                             $time, want.char_valid, o_out.char_valid);
                    mismatches++;
                end
                if (o_out.char_value !== want.char_value) begin
                    $display("%0t: char_value mismatch: expected 0x%02h actual 0x%02h",
                             $time, want.char_value, o_out.char_value);
                    mismatches++;
                end
                if (o_out.div_fault !== want.div_fault) begin
                    $display("%0t: div_fault mismatch: expected %0d actual %0d",
                             $time, want.div_fault, o_out.div_fault);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_row dir_tab [N_DIRECTED];

        // Directed table. Register contents after each row are noted where
        // later rows rely on them. Rows with a typed result are the ones whose
        // answer is plain: reset values, divide by zero, extreme characters.
        dir_tab[0]  = '{mk(rfalu_pkg::CMD_OUT, 3'd0, 3'd0, 3'd0, 32'h0, 9'h0),
                        TYPED, RES_CHAR00};
        dir_tab[1]  = '{mk(rfalu_pkg::CMD_DIV, 3'd1, 3'd0, 3'd2, 32'h0, 9'h0),
                        TYPED, RES_FAULT};
        dir_tab[2]  = '{mk(rfalu_pkg::CMD_LDI, 3'd1, 3'd0, 3'd0, rfalu_pkg::ALL_ONES, 9'h0),
                        TYPED, RES_QUIET};
        dir_tab[3]  = '{mk(rfalu_pkg::CMD_LDI, 3'd2, 3'd0, 3'd0, 32'h3, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[4]  = '{mk(rfalu_pkg::CMD_OUT, 3'd0, 3'd0, 3'd1, 32'h0, 9'h0),
                        TYPED, RES_CHARFF};
        // Add and multiply both wrap: r3 = 2, r4 = 1.
        dir_tab[5]  = '{mk(rfalu_pkg::CMD_ADD, 3'd3, 3'd1, 3'd2, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[6]  = '{mk(rfalu_pkg::CMD_MUL, 3'd4, 3'd1, 3'd1, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[7]  = '{mk(rfalu_pkg::CMD_DIV, 3'd5, 3'd1, 3'd2, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[8]  = '{mk(rfalu_pkg::CMD_NAND, 3'd6, 3'd1, 3'd2, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        // Conditional move with a zero condition, then with a nonzero one.
        dir_tab[9]  = '{mk(rfalu_pkg::CMD_CMOV, 3'd7, 3'd1, 3'd0, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[10] = '{mk(rfalu_pkg::CMD_CMOV, 3'd7, 3'd1, 3'd2, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        // Input of a plain byte, end of input at 256 and at 511, top byte.
        dir_tab[11] = '{mk(rfalu_pkg::CMD_IN, 3'd0, 3'd0, 3'd0, 32'h0, 9'h041),
                        PREDICTED, RES_QUIET};
        dir_tab[12] = '{mk(rfalu_pkg::CMD_IN, 3'd0, 3'd0, 3'd6, 32'h0, 9'h100),
                        PREDICTED, RES_QUIET};
        dir_tab[13] = '{mk(rfalu_pkg::CMD_IN, 3'd0, 3'd0, 3'd5, 32'h0, 9'h1FF),
                        PREDICTED, RES_QUIET};
        dir_tab[14] = '{mk(rfalu_pkg::CMD_IN, 3'd0, 3'd0, 3'd4, 32'h0, 9'h0FF),
                        PREDICTED, RES_QUIET};
        dir_tab[15] = '{mk(rfalu_pkg::CMD_LDI, 3'd0, 3'd0, 3'd0, 32'h8000_0000, 9'h0),
                        PREDICTED, RES_QUIET};
        // All ones divided by 255, then a divide by a register just cleared:
        // r3 must keep its quotient through the faulting divide.
        dir_tab[16] = '{mk(rfalu_pkg::CMD_DIV, 3'd3, 3'd7, 3'd4, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[17] = '{mk(rfalu_pkg::CMD_LDI, 3'd2, 3'd0, 3'd0, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[18] = '{mk(rfalu_pkg::CMD_DIV, 3'd3, 3'd1, 3'd2, 32'h0, 9'h0),
                        TYPED, RES_FAULT};
        dir_tab[19] = '{mk(rfalu_pkg::CMD_OUT, 3'd0, 3'd0, 3'd3, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[20] = '{mk(rfalu_pkg::CMD_MUL, 3'd0, 3'd0, 3'd7, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[21] = '{mk(rfalu_pkg::CMD_OUT, 3'd0, 3'd0, 3'd0, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        // Same register as dividend and divisor, then as destination and sources.
        dir_tab[22] = '{mk(rfalu_pkg::CMD_DIV, 3'd4, 3'd1, 3'd1, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[23] = '{mk(rfalu_pkg::CMD_ADD, 3'd5, 3'd5, 3'd5, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};
        dir_tab[24] = '{mk(rfalu_pkg::CMD_OUT, 3'd0, 3'd0, 3'd5, 32'h0, 9'h0),
                        PREDICTED, RES_QUIET};

        foreach (reg_copy[i]) reg_copy[i] = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].res);
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalling, both a
        // little. The first and third phases start with a long hold-off on the
        // output while items keep coming, which backs the block up to its
        // input. Each phase ends with the sender waiting for every result.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if (ph == 0 || ph == 2) holds_requested = holds_requested + 1;
            @(negedge i_clk);
            repeat (RANDOM_ITEMS / N_PHASES) send_op(rand_op(), PREDICTED, RES_QUIET);
            wait_drained();
        end

        // Leave room for a result that should not come.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** register_file_alu_ops: PASSED **");
        end else begin
            $display("** register_file_alu_ops: FAILED **");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("** register_file_alu_ops: FAILED **");
        $finish;
    end

endmodule
